[hdl/sefr_pkg.sv]
// Shared types and character constants for the STX/ETX byte-stuffing framer.
`timescale 1ns / 1ps

package sefr_pkg;

  // Framing characters (ASCII).
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_E = 8'h45;

  // Room for the run of line bytes one input beat can cause. The bound counts
  // a start sequence, three escaped payload bytes and the end sequence. A real
  // run never exceeds nine bytes: three escaped bytes flushed with the end
  // sequence.
  localparam int RUN_MAX   = 12;
  localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_done;
  } out_beat_t;

  // Lookahead window and framing state.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [1:0] count;
    logic       inside_frame;
  } window_t;

  // Run of line bytes caused by one input beat, oldest in slot 0.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0]  bytes;
    logic [RUN_MAX-1:0]       done;
    logic [RUN_CNT_W-1:0]     count;
  } run_t;

endpackage

[hdl/sefr_run_build.sv]
// Builds the run of stuffed line bytes for one payload beat and the next window state.
`timescale 1ns / 1ps

module sefr_run_build import sefr_pkg::*; (
  input  in_beat_t beat,
  input  window_t  win,
  output run_t     run,
  output window_t  win_next
);

  logic [7:0]           b;
  logic [1:0]           held;
  logic [RUN_CNT_W-1:0] pos;
  logic [2:0][7:0]      fb;
  logic [1:0]           len;
  logic [2:0]           fb_stx;
  logic                 esc;

  assign b    = beat.payload_byte;
  assign held = (win.count == 2'd3) ? 2'd2 : win.count;

  // Bytes flushed on the last beat: held bytes followed by the new one.
  assign fb[0] = (held != 2'd0) ? win.byte0 : b;
  assign fb[1] = (held == 2'd2) ? win.byte1 : b;
  assign fb[2] = b;
  assign len   = held + 2'd1;

  // Only the first flushed byte can have two more bytes behind it.
  assign fb_stx[0] = (len == 2'd3) && (fb[1] == CH_T) && (fb[2] == CH_X);
  assign fb_stx[1] = 1'b0;
  assign fb_stx[2] = 1'b0;

  always_comb begin
    run      = '0;
    pos      = '0;
    win_next = win;
    esc      = 1'b0;

    if (!win.inside_frame) begin
      run.bytes[pos] = CH_S; pos = pos + RUN_CNT_W'(1);
      run.bytes[pos] = CH_T; pos = pos + RUN_CNT_W'(1);
      run.bytes[pos] = CH_X; pos = pos + RUN_CNT_W'(1);
      win_next.inside_frame = 1'b1;
    end

    if (!beat.frame_last) begin
      if (held == 2'd0) begin
        win_next.byte0 = b;
        win_next.count = 2'd1;
      end else if (held == 2'd1) begin
        win_next.byte1 = b;
        win_next.count = 2'd2;
      end else begin
        esc = (win.byte0 == CH_E) ||
              ((win.byte0 == CH_S) && (win.byte1 == CH_T) && (b == CH_X));
        if (esc) begin
          run.bytes[pos] = CH_E; pos = pos + RUN_CNT_W'(1);
        end
        run.bytes[pos] = win.byte0; pos = pos + RUN_CNT_W'(1);
        win_next.byte0 = win.byte1;
        win_next.byte1 = b;
        win_next.count = 2'd2;
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(len)) begin
          if ((fb[k] == CH_E) || ((fb[k] == CH_S) && fb_stx[k])) begin
            run.bytes[pos] = CH_E; pos = pos + RUN_CNT_W'(1);
          end
          run.bytes[pos] = fb[k]; pos = pos + RUN_CNT_W'(1);
        end
      end
      run.bytes[pos] = CH_E; pos = pos + RUN_CNT_W'(1);
      run.bytes[pos] = CH_T; pos = pos + RUN_CNT_W'(1);
      run.bytes[pos] = CH_X;
      run.done[pos]  = 1'b1;
      pos = pos + RUN_CNT_W'(1);
      win_next = '0;
    end

    run.count = pos;
  end

endmodule

[hdl/stx_etx_byte_stuffing_framer_top.sv]
// Top level of the STX/ETX byte-stuffing framer: input register, run buffer and line output.
`timescale 1ns / 1ps

// This block frames payload bytes for a serial line. The first byte of a
// frame is preceded by S,T,X; an escape E is inserted before every payload E
// and before any payload S that starts S,T,X within the frame; the beat
// marked frame_last flushes the two-byte lookahead window and is followed by
// E,T,X, with frame_done high on that final X. Each accepted item beat is
// held in an input register; once the run buffer is free the stuffing logic
// turns it into a run of zero to nine line bytes, which is loaded into the run
// buffer and shifted out one beat per cycle while result_ready is high,
// run_last marking the final beat of the run. The line side therefore sets
// the rate: an item waits until the run before it has drained, so plain
// payload streams at one item per cycle while result_ready stays high. The
// input register lets the next item be taken while the current run still
// drains, and a new run loads in the same cycle that the last beat of the
// previous one is taken. Reset is synchronous on rst and leaves the block
// awaiting a frame start with an empty window.
module stx_etx_byte_stuffing_framer_top import sefr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_beat_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_beat_t result
);

  // Input register.
  logic     hold_valid;
  in_beat_t hold;

  // Window state and the run buffer being sent.
  window_t win;
  window_t win_next;
  run_t    run;
  run_t    run_new;

  logic run_take;
  logic run_free;
  logic hold_move;

  sefr_run_build u_run_build (
    .beat     (hold),
    .win      (win),
    .run      (run_new),
    .win_next (win_next)
  );

  assign result_valid = (run.count != '0);
  assign run_take     = result_valid && result_ready;

  // The run buffer can take a new run when it is empty or its last beat
  // leaves this cycle.
  assign run_free   = (run.count == '0) ||
                      ((run.count == RUN_CNT_W'(1)) && result_ready);
  assign hold_move  = hold_valid && run_free;
  assign item_ready = !hold_valid || hold_move;

  assign result.line_byte  = run.bytes[0];
  assign result.run_last   = (run.count == RUN_CNT_W'(1));
  assign result.frame_done = run.done[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      win        <= '0;
      run.count  <= '0;
    end else begin
      if (item_valid && item_ready) begin
        hold_valid <= 1'b1;
        hold       <= item;
      end else if (hold_move) begin
        hold_valid <= 1'b0;
      end

      if (hold_move) begin
        win <= win_next;
        run <= run_new;
      end else if (run_take) begin
        run.bytes <= run.bytes >> 8;
        run.done  <= run.done >> 1;
        run.count <= run.count - RUN_CNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  // The run buffer never holds more than the longest possible run.
  assert property (@(posedge clk) disable iff (rst)
    run.count <= RUN_CNT_W'(RUN_MAX))
    else $error("run buffer count exceeds maximum run length");

  // The window never claims three held bytes.
  assert property (@(posedge clk) disable iff (rst)
    win.count != 2'd3)
    else $error("lookahead window count out of range");

  // A frame_done beat only ends a run.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_done |-> result.run_last)
    else $error("frame_done on a beat that is not the end of its run");

  // When the end sequence leaves, the window has already been cleared.
  assert property (@(posedge clk) disable iff (rst)
    run_take && result.frame_done |-> !win.inside_frame && (win.count == 2'd0))
    else $error("window not cleared at frame end");

  // A run does not stop before its last beat.
  assert property (@(posedge clk) disable iff (rst)
    run_take && !result.run_last |=> result_valid)
    else $error("run ended early");
`endif

endmodule
